FILE: hdl/dvcm_pkg.sv
// ----------------------------------------------------------------------------
// Di-tau mass package
// Widths shared by the pipeline, the root and divider units, and the channel
// interfaces.
// ----------------------------------------------------------------------------
package dvcm_pkg;

    localparam int MOMENTUM_BITS = 24;
    localparam int W             = MOMENTUM_BITS;

    // Quotient width of the neutrino solve; larger results saturate.
    localparam int Q_W      = W + 8;
    // Divider numerator and denominator.
    localparam int NUM_W    = 3 * W + 2;
    localparam int DEN_W    = 2 * W + 1;

    // Magnitude of the summed collinear components, and of its square.
    localparam int TM_W     = Q_W + 2;
    localparam int SQR_W    = 2 * TM_W;

    // Square root unit: root bits, radicand, partial remainder, rounded root.
    localparam int SQ_W     = TM_W;
    localparam int SQ_IN_W  = 2 * SQ_W;
    localparam int SQ_REM_W = SQ_W + 2;
    localparam int SQ_OUT_W = SQ_W + 1;

    localparam int SQ_LAT   = SQ_W + 1;
    localparam int DIV_LAT  = Q_W + 1;

endpackage

FILE: hdl/dvcm_if.sv
// ----------------------------------------------------------------------------
// Di-tau mass channels
// Valid/ready channels for the event request and for its mass result.
// ----------------------------------------------------------------------------
interface dvcm_in_if import dvcm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] lep1_px;
    logic signed [W-1:0] lep1_py;
    logic signed [W-1:0] lep1_pz;
    logic [W-1:0]        lep1_energy;
    logic signed [W-1:0] lep2_px;
    logic signed [W-1:0] lep2_py;
    logic signed [W-1:0] lep2_pz;
    logic [W-1:0]        lep2_energy;
    logic signed [W-1:0] missing_px;
    logic signed [W-1:0] missing_py;

    modport source (
        output valid, lep1_px, lep1_py, lep1_pz, lep1_energy,
        output lep2_px, lep2_py, lep2_pz, lep2_energy, missing_px, missing_py,
        input  ready
    );
    modport sink (
        input  valid, lep1_px, lep1_py, lep1_pz, lep1_energy,
        input  lep2_px, lep2_py, lep2_pz, lep2_energy, missing_px, missing_py,
        output ready
    );
endinterface

interface dvcm_out_if import dvcm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [W-1:0]        visible_mass;
    logic [W-1:0]        collinear_mass;
    logic signed [W-1:0] nu1_momentum;
    logic signed [W-1:0] nu2_momentum;
    logic                visible_invalid;
    logic                collinear_invalid;

    modport source (
        output valid, visible_mass, collinear_mass, nu1_momentum, nu2_momentum,
        output visible_invalid, collinear_invalid,
        input  ready
    );
    modport sink (
        input  valid, visible_mass, collinear_mass, nu1_momentum, nu2_momentum,
        input  visible_invalid, collinear_invalid,
        output ready
    );
endinterface

FILE: hdl/dvcm_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined square root
// One root bit per stage, then rounding to nearest in a final stage.
// ----------------------------------------------------------------------------
module dvcm_sqrt import dvcm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [SQ_IN_W-1:0]  i_rad,
    output logic [SQ_OUT_W-1:0] o_root
);

    logic [SQ_W-1:0]     r_q   [SQ_W];
    logic [SQ_REM_W-1:0] r_rem [SQ_W];
    logic [SQ_IN_W-1:0]  r_rad [SQ_W-1];
    logic [SQ_OUT_W-1:0] r_root;

    genvar k;
    for (k = 0; k < SQ_W; k++) begin : g_stage
        logic [SQ_W-1:0]     q_in;
        logic [SQ_REM_W-1:0] rem_in;
        logic [SQ_IN_W-1:0]  rad_in;
        logic [SQ_REM_W+1:0] trial;
        logic [SQ_REM_W+1:0] cand;

        if (k == 0) begin : g_first
            assign q_in   = '0;
            assign rem_in = '0;
            assign rad_in = i_rad;
        end else begin : g_next
            assign q_in   = r_q[k-1];
            assign rem_in = r_rem[k-1];
            assign rad_in = r_rad[k-1];
        end

        assign trial = {rem_in, rad_in[SQ_IN_W-1 -: 2]};
        assign cand  = {2'b00, q_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (trial >= cand) begin
                    r_rem[k] <= SQ_REM_W'(trial - cand);
                    r_q[k]   <= {q_in[SQ_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= trial[SQ_REM_W-1:0];
                    r_q[k]   <= {q_in[SQ_W-2:0], 1'b0};
                end
            end
        end

        if (k < SQ_W - 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k] <= {rad_in[SQ_IN_W-3:0], 2'b00};
                end
            end
        end
    end

    // The remainder is x - q*q; above q the nearer root is q + 1.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_rem[SQ_W-1] > {2'b00, r_q[SQ_W-1]}) begin
                r_root <= {1'b0, r_q[SQ_W-1]} + SQ_OUT_W'(1);
            end else begin
                r_root <= {1'b0, r_q[SQ_W-1]};
            end
        end
    end

    assign o_root = r_root;

endmodule

FILE: hdl/dvcm_div.sv
// ----------------------------------------------------------------------------
// Pipelined saturating divider
// Restoring division, one quotient bit per stage, clamped to the quotient range.
// ----------------------------------------------------------------------------
module dvcm_div import dvcm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);

    logic [DEN_W-1:0] r_rem [Q_W+1];
    logic [Q_W-1:0]   r_low [Q_W+1];
    logic [Q_W-1:0]   r_q   [Q_W+1];
    logic [DEN_W-1:0] r_den [Q_W+1];
    logic             r_ovf [Q_W+1];

    // The quotient overflows exactly when the upper numerator reaches the divisor.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= DEN_W'(i_num[NUM_W-1:Q_W]) >= i_den;
            r_rem[0] <= DEN_W'(i_num[NUM_W-1:Q_W]);
            r_low[0] <= i_num[Q_W-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
        end
    end

    genvar k;
    for (k = 1; k <= Q_W; k++) begin : g_stage
        logic [DEN_W:0] trial;

        assign trial = {r_rem[k-1], r_low[k-1][Q_W-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (trial >= {1'b0, r_den[k-1]}) begin
                    r_rem[k] <= DEN_W'(trial - {1'b0, r_den[k-1]});
                    r_q[k]   <= {r_q[k-1][Q_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= trial[DEN_W-1:0];
                    r_q[k]   <= {r_q[k-1][Q_W-2:0], 1'b0};
                end
                r_low[k] <= {r_low[k-1][Q_W-2:0], 1'b0};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_ovf[Q_W] ? {Q_W{1'b1}} : r_q[Q_W];

endmodule

FILE: hdl/ditau_visible_and_collinear_mass.sv
// ----------------------------------------------------------------------------
// Di-tau visible and collinear mass
// Visible pair mass and collinear-approximation mass of two leptons and the
// missing transverse momentum.
// ----------------------------------------------------------------------------
// The block takes one request per clock; each request passes through the two
// 35-stage square root pipelines (lepton momenta with the visible mass, then
// the collinear mass) and the 33-stage divider lanes that solve the eight
// neutrino components. When a result is not taken, the whole pipeline holds
// and input ready drops until it moves.
module ditau_visible_and_collinear_mass import dvcm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dvcm_in_if.sink      i_in,
    dvcm_out_if.source   o_out
);

    localparam int SUM_W     = W + 1;
    localparam int PROD_W    = 2 * W;
    localparam int DET_W     = 2 * W + 1;
    localparam int MAG_W     = 2 * W;
    localparam int HALF_W    = W;
    localparam int C_W       = W + 1;
    localparam int PP_W      = HALF_W + C_W;
    localparam int RP_W      = 2 * W;
    localparam int VSQ_W     = 2 * SUM_W;
    localparam int VM2_W     = VSQ_W + 2;
    localparam int NE_W      = Q_W + 1;
    localparam int TOT_W     = Q_W + 3;
    localparam int TM_LO     = TM_W / 2;
    localparam int M2_W      = SQR_W + 2;
    localparam int LANES     = 8;
    localparam int TOTAL_LAT = 4 + SQ_LAT + 2 + DIV_LAT + 5 + SQ_LAT + 1;

    typedef struct packed {
        logic signed [W-1:0] x1;
        logic signed [W-1:0] y1;
        logic signed [W-1:0] z1;
        logic signed [W-1:0] x2;
        logic signed [W-1:0] y2;
        logic signed [W-1:0] z2;
    } t_coord;

    typedef struct packed {
        t_coord                  c;
        logic [SUM_W-1:0]        esum;
        logic signed [SUM_W-1:0] xsum;
        logic signed [SUM_W-1:0] ysum;
        logic signed [SUM_W-1:0] zsum;
        logic [MAG_W-1:0]        dmag;
        logic [MAG_W-1:0]        n1mag;
        logic [MAG_W-1:0]        n2mag;
        logic                    sd;
        logic                    sn1;
        logic                    sn2;
        logic                    dzero;
        logic                    vbad;
    } t_side1;

    typedef struct packed {
        logic [SUM_W-1:0]        esum;
        logic signed [SUM_W-1:0] xsum;
        logic signed [SUM_W-1:0] ysum;
        logic signed [SUM_W-1:0] zsum;
        logic [LANES-1:0]        neg;
        logic                    dzero;
        logic [W-1:0]            vis;
        logic                    vbad;
    } t_side2;

    typedef struct packed {
        logic [W-1:0] nu1;
        logic [W-1:0] nu2;
        logic         dzero;
        logic [W-1:0] vis;
        logic         vbad;
        logic         cbad;
    } t_side3;

    function automatic logic [C_W-1:0] abs_c(input logic signed [W-1:0] v);
        logic signed [C_W-1:0] t;
        t = C_W'(v);
        return v[W-1] ? C_W'(-t) : C_W'(t);
    endfunction

    function automatic logic [TM_W-1:0] abs_t(input logic signed [TOT_W-1:0] v);
        return v[TOT_W-1] ? TM_W'(-v) : TM_W'(v);
    endfunction

    function automatic logic [W-1:0] sat_nu(input logic signed [NE_W-1:0] v);
        if (!v[NE_W-1] && (|v[NE_W-2:W-1])) begin
            return {1'b0, {(W-1){1'b1}}};
        end else if (v[NE_W-1] && !(&v[NE_W-2:W-1])) begin
            return {1'b1, {(W-1){1'b0}}};
        end
        return v[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_mass(input logic [SQ_OUT_W-1:0] r);
        return (|r[SQ_OUT_W-1:W]) ? {W{1'b1}} : r[W-1:0];
    endfunction

    logic                 en;
    logic [TOTAL_LAT-1:0] r_vld;

    assign en         = !r_vld[TOTAL_LAT-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_in.valid};
        end
    end

    // ---------------- stage 1: input register
    t_coord              r1_c;
    logic signed [W-1:0] r1_mx, r1_my;
    logic [W-1:0]        r1_e1, r1_e2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_c.x1 <= i_in.lep1_px;
            r1_c.y1 <= i_in.lep1_py;
            r1_c.z1 <= i_in.lep1_pz;
            r1_c.x2 <= i_in.lep2_px;
            r1_c.y2 <= i_in.lep2_py;
            r1_c.z2 <= i_in.lep2_pz;
            r1_e1   <= i_in.lep1_energy;
            r1_e2   <= i_in.lep2_energy;
            r1_mx   <= i_in.missing_px;
            r1_my   <= i_in.missing_py;
        end
    end

    // ---------------- stage 2: cross products, squares and visible sums
    t_coord                   r2_c;
    logic signed [PROD_W-1:0] r2_x1y2, r2_x2y1, r2_mxy2, r2_myx2, r2_x1my, r2_mxy1;
    logic [PROD_W-1:0]        r2_sx1, r2_sy1, r2_sz1, r2_sx2, r2_sy2, r2_sz2;
    logic [SUM_W-1:0]         r2_ve;
    logic signed [SUM_W-1:0]  r2_vx, r2_vy, r2_vz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_c    <= r1_c;
            r2_x1y2 <= PROD_W'(r1_c.x1) * PROD_W'(r1_c.y2);
            r2_x2y1 <= PROD_W'(r1_c.x2) * PROD_W'(r1_c.y1);
            r2_mxy2 <= PROD_W'(r1_mx) * PROD_W'(r1_c.y2);
            r2_myx2 <= PROD_W'(r1_my) * PROD_W'(r1_c.x2);
            r2_x1my <= PROD_W'(r1_c.x1) * PROD_W'(r1_my);
            r2_mxy1 <= PROD_W'(r1_mx) * PROD_W'(r1_c.y1);
            r2_sx1  <= PROD_W'(r1_c.x1) * PROD_W'(r1_c.x1);
            r2_sy1  <= PROD_W'(r1_c.y1) * PROD_W'(r1_c.y1);
            r2_sz1  <= PROD_W'(r1_c.z1) * PROD_W'(r1_c.z1);
            r2_sx2  <= PROD_W'(r1_c.x2) * PROD_W'(r1_c.x2);
            r2_sy2  <= PROD_W'(r1_c.y2) * PROD_W'(r1_c.y2);
            r2_sz2  <= PROD_W'(r1_c.z2) * PROD_W'(r1_c.z2);
            r2_ve   <= SUM_W'(r1_e1) + SUM_W'(r1_e2);
            r2_vx   <= SUM_W'(r1_c.x1) + SUM_W'(r1_c.x2);
            r2_vy   <= SUM_W'(r1_c.y1) + SUM_W'(r1_c.y2);
            r2_vz   <= SUM_W'(r1_c.z1) + SUM_W'(r1_c.z2);
        end
    end

    // ---------------- stage 3: determinant, numerators, |p|^2, visible squares
    t_coord                  r3_c;
    logic signed [DET_W-1:0] r3_det, r3_n1, r3_n2;
    logic [RP_W-1:0]         r3_rp1, r3_rp2;
    logic [VSQ_W-1:0]        r3_ve2, r3_vx2, r3_vy2, r3_vz2;
    logic [SUM_W-1:0]        r3_ve;
    logic signed [SUM_W-1:0] r3_vx, r3_vy, r3_vz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_c   <= r2_c;
            r3_det <= DET_W'(r2_x1y2) - DET_W'(r2_x2y1);
            r3_n1  <= DET_W'(r2_mxy2) - DET_W'(r2_myx2);
            r3_n2  <= DET_W'(r2_x1my) - DET_W'(r2_mxy1);
            r3_rp1 <= RP_W'(r2_sx1) + RP_W'(r2_sy1) + RP_W'(r2_sz1);
            r3_rp2 <= RP_W'(r2_sx2) + RP_W'(r2_sy2) + RP_W'(r2_sz2);
            r3_ve2 <= VSQ_W'(r2_ve) * VSQ_W'(r2_ve);
            r3_vx2 <= VSQ_W'(r2_vx) * VSQ_W'(r2_vx);
            r3_vy2 <= VSQ_W'(r2_vy) * VSQ_W'(r2_vy);
            r3_vz2 <= VSQ_W'(r2_vz) * VSQ_W'(r2_vz);
            r3_ve  <= r2_ve;
            r3_vx  <= r2_vx;
            r3_vy  <= r2_vy;
            r3_vz  <= r2_vz;
        end
    end

    // ---------------- stage 4: magnitudes and signs, visible mass squared
    t_side1           n4_s;
    logic [VM2_W-1:0] n4_vm2;
    t_side1           r4_s;
    logic [RP_W-1:0]  r4_rp1, r4_rp2;
    logic [VM2_W-1:0] r4_vm2;

    always_comb begin
        n4_vm2     = VM2_W'(r3_ve2) - VM2_W'(r3_vx2) - VM2_W'(r3_vy2) - VM2_W'(r3_vz2);
        n4_s.c     = r3_c;
        n4_s.esum  = r3_ve;
        n4_s.xsum  = r3_vx;
        n4_s.ysum  = r3_vy;
        n4_s.zsum  = r3_vz;
        n4_s.sd    = r3_det[DET_W-1];
        n4_s.sn1   = r3_n1[DET_W-1];
        n4_s.sn2   = r3_n2[DET_W-1];
        n4_s.dmag  = MAG_W'(r3_det[DET_W-1] ? -r3_det : r3_det);
        n4_s.n1mag = MAG_W'(r3_n1[DET_W-1] ? -r3_n1 : r3_n1);
        n4_s.n2mag = MAG_W'(r3_n2[DET_W-1] ? -r3_n2 : r3_n2);
        n4_s.dzero = r3_det == '0;
        n4_s.vbad  = n4_vm2[VM2_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_s   <= n4_s;
            r4_rp1 <= r3_rp1;
            r4_rp2 <= r3_rp2;
            r4_vm2 <= n4_vm2;
        end
    end

    // ---------------- first root pipeline: |p1|, |p2| and the visible mass
    logic [SQ_IN_W-1:0]  vis_rad;
    logic [SQ_OUT_W-1:0] p1_root, p2_root, vis_root;
    t_side1              r_d1 [SQ_LAT];

    assign vis_rad = r4_vm2[VM2_W-1] ? '0 : SQ_IN_W'(r4_vm2);

    dvcm_sqrt u_sqrt_p1 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (SQ_IN_W'(r4_rp1)),
        .o_root (p1_root)
    );

    dvcm_sqrt u_sqrt_p2 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (SQ_IN_W'(r4_rp2)),
        .o_root (p2_root)
    );

    dvcm_sqrt u_sqrt_vis (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (vis_rad),
        .o_root (vis_root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1[0] <= r4_s;
            for (int i = 1; i < SQ_LAT; i++) begin
                r_d1[i] <= r_d1[i-1];
            end
        end
    end

    // ---------------- stage M1: partial products of |N| * |c| for each lane
    // Lanes 0..3 take neutrino 1 with |p1|, x1, y1, z1; lanes 4..7 neutrino 2.
    t_side1           s1;
    logic [C_W-1:0]   cm   [LANES];
    logic [LANES-1:0] cneg;
    logic [MAG_W-1:0] nm   [LANES];
    logic [LANES-1:0] nneg;
    t_side2           n5_s;
    t_side2           r5_s;
    logic [MAG_W-1:0] r5_dmag;
    logic [PP_W-1:0]  r5_pplo [LANES];
    logic [PP_W-1:0]  r5_pphi [LANES];

    always_comb begin
        s1    = r_d1[SQ_LAT-1];
        cm[0] = C_W'(p1_root);
        cm[1] = abs_c(s1.c.x1);
        cm[2] = abs_c(s1.c.y1);
        cm[3] = abs_c(s1.c.z1);
        cm[4] = C_W'(p2_root);
        cm[5] = abs_c(s1.c.x2);
        cm[6] = abs_c(s1.c.y2);
        cm[7] = abs_c(s1.c.z2);
        cneg  = {s1.c.z2[W-1], s1.c.y2[W-1], s1.c.x2[W-1], 1'b0,
                 s1.c.z1[W-1], s1.c.y1[W-1], s1.c.x1[W-1], 1'b0};
        for (int l = 0; l < LANES; l++) begin
            nm[l]   = (l < LANES / 2) ? s1.n1mag : s1.n2mag;
            nneg[l] = (l < LANES / 2) ? s1.sn1 : s1.sn2;
        end
        n5_s.esum  = s1.esum;
        n5_s.xsum  = s1.xsum;
        n5_s.ysum  = s1.ysum;
        n5_s.zsum  = s1.zsum;
        n5_s.neg   = nneg ^ cneg ^ {LANES{s1.sd}};
        n5_s.dzero = s1.dzero;
        n5_s.vis   = s1.vbad ? '0 : sat_mass(vis_root);
        n5_s.vbad  = s1.vbad;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_s    <= n5_s;
            r5_dmag <= s1.dmag;
            for (int l = 0; l < LANES; l++) begin
                r5_pplo[l] <= PP_W'(nm[l][HALF_W-1:0]) * PP_W'(cm[l]);
                r5_pphi[l] <= PP_W'(nm[l][MAG_W-1:HALF_W]) * PP_W'(cm[l]);
            end
        end
    end

    // ---------------- stage M2: numerator 2|N||c| + |D|, divisor 2|D|
    t_side2           r6_s;
    logic [NUM_W-1:0] r6_num [LANES];
    logic [DEN_W-1:0] r6_den;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_s   <= r5_s;
            r6_den <= DEN_W'(r5_dmag) << 1;
            for (int l = 0; l < LANES; l++) begin
                r6_num[l] <= (NUM_W'(r5_pphi[l]) << (HALF_W + 1))
                           + (NUM_W'(r5_pplo[l]) << 1) + NUM_W'(r5_dmag);
            end
        end
    end

    // ---------------- divider lanes
    logic [Q_W-1:0] quo [LANES];
    t_side2         r_d2 [DIV_LAT];

    genvar g;
    for (g = 0; g < LANES; g++) begin : g_lane
        dvcm_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r6_num[g]),
            .i_den (r6_den),
            .o_quo (quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2[0] <= r6_s;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_d2[i] <= r_d2[i-1];
            end
        end
    end

    // ---------------- stage A: signed components and summed four-vector
    t_side2                  s2;
    logic signed [NE_W-1:0]  ne [LANES];
    t_side3                  n7_s;
    t_side3                  r7_s;
    logic signed [TOT_W-1:0] r7_t [4];

    always_comb begin
        s2 = r_d2[DIV_LAT-1];
        for (int l = 0; l < LANES; l++) begin
            ne[l] = s2.neg[l] ? -NE_W'(quo[l]) : NE_W'(quo[l]);
        end
        n7_s.nu1   = sat_nu(ne[0]);
        n7_s.nu2   = sat_nu(ne[4]);
        n7_s.dzero = s2.dzero;
        n7_s.vis   = s2.vis;
        n7_s.vbad  = s2.vbad;
        n7_s.cbad  = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_s    <= n7_s;
            r7_t[0] <= TOT_W'(s2.esum) + TOT_W'(ne[0]) + TOT_W'(ne[4]);
            r7_t[1] <= TOT_W'(s2.xsum) + TOT_W'(ne[1]) + TOT_W'(ne[5]);
            r7_t[2] <= TOT_W'(s2.ysum) + TOT_W'(ne[2]) + TOT_W'(ne[6]);
            r7_t[3] <= TOT_W'(s2.zsum) + TOT_W'(ne[3]) + TOT_W'(ne[7]);
        end
    end

    // ---------------- stages B to E: magnitudes, split squares, mass squared
    t_side3             r8_s, r9_s, r10_s, r11_s;
    logic [TM_W-1:0]    r8_m  [4];
    logic [SQR_W-1:0]   r9_ph [4];
    logic [SQR_W-1:0]   r9_pl [4];
    logic [SQR_W-1:0]   r10_sq [4];
    logic [M2_W-1:0]    m2;
    t_side3             n11_s;
    logic [SQ_IN_W-1:0] r11_rad;

    always_comb begin
        m2 = M2_W'(r10_sq[0]) - M2_W'(r10_sq[1]) - M2_W'(r10_sq[2]) - M2_W'(r10_sq[3]);
        n11_s      = r10_s;
        n11_s.cbad = m2[M2_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_s  <= r7_s;
            r9_s  <= r8_s;
            r10_s <= r9_s;
            r11_s <= n11_s;
            for (int j = 0; j < 4; j++) begin
                r8_m[j]   <= abs_t(r7_t[j]);
                r9_ph[j]  <= SQR_W'(r8_m[j][TM_W-1:TM_LO]) * SQR_W'(r8_m[j]);
                r9_pl[j]  <= SQR_W'(r8_m[j][TM_LO-1:0]) * SQR_W'(r8_m[j]);
                r10_sq[j] <= (r9_ph[j] << TM_LO) + r9_pl[j];
            end
            r11_rad <= m2[M2_W-1] ? '0 : SQ_IN_W'(m2);
        end
    end

    // ---------------- second root pipeline: collinear mass
    logic [SQ_OUT_W-1:0] col_root;
    t_side3              r_d3 [SQ_LAT];
    t_side3              s3;

    dvcm_sqrt u_sqrt_col (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r11_rad),
        .o_root (col_root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d3[0] <= r11_s;
            for (int i = 1; i < SQ_LAT; i++) begin
                r_d3[i] <= r_d3[i-1];
            end
        end
    end

    // ---------------- output register
    logic [W-1:0] r_o_vis, r_o_col, r_o_nu1, r_o_nu2;
    logic         r_o_vbad, r_o_cbad;

    assign s3 = r_d3[SQ_LAT-1];

    // A zero determinant clears the neutrino solution as well as the mass.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_vis  <= s3.vis;
            r_o_vbad <= s3.vbad;
            r_o_cbad <= s3.dzero || s3.cbad;
            r_o_col  <= (s3.dzero || s3.cbad) ? '0 : sat_mass(col_root);
            r_o_nu1  <= s3.dzero ? '0 : s3.nu1;
            r_o_nu2  <= s3.dzero ? '0 : s3.nu2;
        end
    end

    assign o_out.valid             = r_vld[TOTAL_LAT-1];
    assign o_out.visible_mass      = r_o_vis;
    assign o_out.collinear_mass    = r_o_col;
    assign o_out.nu1_momentum      = r_o_nu1;
    assign o_out.nu2_momentum      = r_o_nu2;
    assign o_out.visible_invalid   = r_o_vbad;
    assign o_out.collinear_invalid = r_o_cbad;

endmodule
